// ===== rtl/core/bst_pkg.sv =====
// shared types and codes for the bounded sequence table
package bst_pkg;

  localparam int unsigned CAPACITY_DEF    = 256;
  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned CMPW            = 16;

  typedef logic [CMPW-1:0] cnt_t;

  typedef enum logic [2:0] {
    CM_HOLD,
    CM_SHL,
    CM_DROP,
    CM_PUTL,
    CM_INSAT,
    CM_ERASE,
    CM_SET
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    cnt_t     len;
    cnt_t     pos;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    CMD_INSERT_AT     = 3'd0,
    CMD_INSERT_SORTED = 3'd1,
    CMD_ERASE_AT      = 3'd2,
    CMD_REMOVE_VALUE  = 3'd3,
    CMD_GET           = 3'd4,
    CMD_SET           = 3'd5,
    CMD_FIND          = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

endpackage

// ===== rtl/core/bounded_sequence_table_core.sv =====
// bounded sequence table: command sequencer and chain of entry cells
//
//  channel  | ports                                              | handshake
//  request  | command_i position_i item_value_i                  | start & !busy
//  result   | status_o result_index_o removed_count_o            | done_o, one cycle
//           | read_value_o fill_count_o is_empty_o               |
//
// insert_at, erase_at, set and commands failing a range or full check finish in S_EXEC.
// insert_sorted, remove_value, get and find rotate the chain once through S_SCAN, one
// entry per cycle, except that insert_sorted holds the rotation while it places the
// value ahead of an existing entry.
// reset clears the fill count and the sequencer; entry cells are not cleared.
// results cannot be stalled; busy is low again in the cycle done_o is shown.
module bounded_sequence_table_core import bst_pkg::*; #(
  parameter int unsigned CAPACITY    = CAPACITY_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command_i,
  input  logic [7:0]  position_i,
  input  logic [31:0] item_value_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [7:0]  result_index_o,
  output logic [8:0]  removed_count_o,
  output logic [31:0] read_value_o,
  output logic [8:0]  fill_count_o,
  output logic        is_empty_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned VW = VALUE_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_SCAN = 3'b100
  } state_e;

  state_e        state_q, state_d;
  logic [2:0]    cmd_q, cmd_d;
  cnt_t          pos_q, pos_d;
  logic [VW-1:0] val_q, val_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] len_q, len_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [CW-1:0] k_q, k_d;
  logic          found_q, found_d;
  status_e       status_q, status_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] rmv_q, rmv_d;
  logic [VW-1:0] rdv_q, rdv_d;
  logic          done_q, done_d;

  cell_ctl_t     ctl;
  logic [VW-1:0] cell_data [CAPACITY];
  logic [VW-1:0] head;
  logic          pos_gt, pos_ge, full;

  assign head   = cell_data[0];
  assign pos_gt = pos_q > cnt_t'(count_q);
  assign pos_ge = pos_q >= cnt_t'(count_q);
  assign full   = count_q >= CW'(CAPACITY);

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    pos_d    = pos_q;
    val_d    = val_q;
    count_d  = count_q;
    len_d    = len_q;
    rem_d    = rem_q;
    k_d      = k_q;
    found_d  = found_q;
    status_d = status_q;
    idx_d    = idx_q;
    rmv_d    = rmv_q;
    rdv_d    = rdv_q;
    done_d   = 1'b0;
    ctl.op   = CM_HOLD;
    ctl.len  = cnt_t'(len_q);
    ctl.pos  = pos_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d   = command_i;
          pos_d   = cnt_t'(position_i);
          val_d   = VW'(item_value_i);
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        status_d = ST_OK;
        idx_d    = '0;
        rmv_d    = '0;
        rdv_d    = '0;
        len_d    = count_q;
        rem_d    = count_q;
        k_d      = '0;
        found_d  = 1'b0;
        done_d   = 1'b1;
        state_d  = S_IDLE;
        case (cmd_q)
          CMD_INSERT_AT: begin
            if (pos_gt) status_d = ST_RANGE;
            else if (full) status_d = ST_FULL;
            else begin
              ctl.op  = CM_INSAT;
              count_d = count_q + 1'b1;
              idx_d   = CW'(pos_q);
            end
          end
          CMD_INSERT_SORTED: begin
            if (full) status_d = ST_FULL;
            else begin
              done_d  = 1'b0;
              state_d = S_SCAN;
            end
          end
          CMD_ERASE_AT: begin
            if (pos_ge) status_d = ST_RANGE;
            else begin
              ctl.op  = CM_ERASE;
              count_d = count_q - 1'b1;
            end
          end
          CMD_SET: begin
            if (pos_ge) status_d = ST_RANGE;
            else ctl.op = CM_SET;
          end
          CMD_GET: begin
            if (pos_ge) status_d = ST_RANGE;
            else begin
              done_d  = 1'b0;
              state_d = S_SCAN;
            end
          end
          CMD_REMOVE_VALUE, CMD_FIND: begin
            done_d  = 1'b0;
            state_d = S_SCAN;
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        if (rem_q != '0) begin
          case (cmd_q)
            CMD_REMOVE_VALUE: begin
              rem_d = rem_q - 1'b1;
              if (head == val_q) begin
                ctl.op = CM_DROP;
                len_d  = len_q - 1'b1;
                rmv_d  = rmv_q + 1'b1;
              end else begin
                ctl.op = CM_SHL;
              end
            end
            CMD_INSERT_SORTED: begin
              if (!found_q && head >= val_q) begin
                ctl.op  = CM_PUTL;
                len_d   = len_q + 1'b1;
                found_d = 1'b1;
                idx_d   = k_q;
              end else begin
                ctl.op = CM_SHL;
                rem_d  = rem_q - 1'b1;
                k_d    = k_q + 1'b1;
              end
            end
            CMD_GET: begin
              ctl.op = CM_SHL;
              rem_d  = rem_q - 1'b1;
              k_d    = k_q + 1'b1;
              if (cnt_t'(k_q) == pos_q) rdv_d = head;
            end
            default: begin
              ctl.op = CM_SHL;
              rem_d  = rem_q - 1'b1;
              k_d    = k_q + 1'b1;
              if (!found_q && head == val_q) begin
                found_d = 1'b1;
                idx_d   = k_q;
              end
            end
          endcase
        end else begin
          count_d = len_q;
          done_d  = 1'b1;
          state_d = S_IDLE;
          if (cmd_q == CMD_INSERT_SORTED && !found_q) begin
            ctl.op  = CM_PUTL;
            idx_d   = k_q;
            count_d = len_q + 1'b1;
          end
          if (cmd_q == CMD_FIND && !found_q) status_d = ST_MISSING;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    pos_q    <= pos_d;
    val_q    <= val_d;
    len_q    <= len_d;
    rem_q    <= rem_d;
    k_q      <= k_d;
    found_q  <= found_d;
    status_q <= status_d;
    idx_q    <= idx_d;
    rmv_q    <= rmv_d;
    rdv_q    <= rdv_d;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VW-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = cell_data[g];
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = cell_data[g];
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end
    bst_cell #(
      .IDX(g),
      .VW (VW)
    ) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .val_i  (val_q),
      .head_i (head),
      .left_i (left_w),
      .right_i(right_w),
      .data_o (cell_data[g])
    );
  end

  assign busy            = state_q != S_IDLE;
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign result_index_o  = 8'(idx_q);
  assign removed_count_o = 9'(rmv_q);
  assign read_value_o    = 32'(rdv_q);
  assign fill_count_o    = 9'(count_q);
  assign is_empty_o      = count_q == '0;

endmodule

// ===== rtl/core/bst_cell.sv =====
// one table entry cell of the chain
module bst_cell import bst_pkg::*; #(
  parameter int unsigned IDX = 0,
  parameter int unsigned VW  = VALUE_WIDTH_DEF
) (
  input  logic          clk_i,
  input  cell_ctl_t     ctl_i,
  input  logic [VW-1:0] val_i,
  input  logic [VW-1:0] head_i,
  input  logic [VW-1:0] left_i,
  input  logic [VW-1:0] right_i,
  output logic [VW-1:0] data_o
);

  localparam cnt_t IdxC  = cnt_t'(IDX);
  localparam cnt_t Idx1C = cnt_t'(IDX + 1);

  logic [VW-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    case (ctl_i.op)
      CM_SHL: begin
        if (Idx1C < ctl_i.len) data_d = right_i;
        else if (Idx1C == ctl_i.len) data_d = head_i;
      end
      CM_DROP: begin
        if (Idx1C < ctl_i.len) data_d = right_i;
      end
      CM_PUTL: begin
        if (IdxC == ctl_i.len) data_d = val_i;
      end
      CM_INSAT: begin
        if (IdxC > ctl_i.pos) data_d = left_i;
        else if (IdxC == ctl_i.pos) data_d = val_i;
      end
      CM_ERASE: begin
        if (IdxC >= ctl_i.pos) data_d = right_i;
      end
      CM_SET: begin
        if (IdxC == ctl_i.pos) data_d = val_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== tb/sv/tb_bounded_sequence_table_core.sv =====
// testbench for bounded_sequence_table_core: directed corners and a random command stream checked against a table model
`timescale 1ns / 100ps

module tb_bounded_sequence_table_core import bst_pkg::*;;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned REPORT_MAX = 10;

  typedef struct {
    status_e     status;
    logic [7:0]  index;
    logic [8:0]  removed;
    logic [31:0] read_value;
    logic [8:0]  fill;
    logic        empty;
  } table_result_t;

  class table_tracker;
    logic [31:0]   entries [TABLE_DEPTH];
    int unsigned   fill_count;
    table_result_t expected_results [$];
    int unsigned   mismatches;

    function new();
      fill_count = 0;
      mismatches = 0;
    endfunction

    function void open_gap(int unsigned at);
      for (int unsigned i = fill_count; i > at; i--) begin
        entries[i] = entries[i-1];
      end
    endfunction

    function void note_request(logic [2:0] cmd, logic [7:0] pos, logic [31:0] val);
      table_result_t r;
      int unsigned w;
      r.status = ST_OK;
      r.index = '0;
      r.removed = '0;
      r.read_value = '0;
      case (cmd)
        CMD_INSERT_AT: begin
          if (pos > fill_count) begin
            r.status = ST_RANGE;
          end else if (fill_count >= TABLE_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            open_gap(pos);
            entries[pos] = val;
            fill_count++;
            r.index = pos;
          end
        end
        CMD_INSERT_SORTED: begin
          if (fill_count >= TABLE_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            w = 0;
            while (w < fill_count && entries[w] < val) w++;
            open_gap(w);
            entries[w] = val;
            fill_count++;
            r.index = w[7:0];
          end
        end
        CMD_ERASE_AT: begin
          if (pos >= fill_count) begin
            r.status = ST_RANGE;
          end else begin
            for (int unsigned i = pos; i + 1 < fill_count; i++) entries[i] = entries[i+1];
            fill_count--;
          end
        end
        CMD_REMOVE_VALUE: begin
          w = 0;
          for (int unsigned i = 0; i < fill_count; i++) begin
            if (entries[i] == val) begin
              r.removed++;
            end else begin
              entries[w] = entries[i];
              w++;
            end
          end
          fill_count = w;
        end
        CMD_GET: begin
          if (pos >= fill_count) r.status = ST_RANGE;
          else r.read_value = entries[pos];
        end
        CMD_SET: begin
          if (pos >= fill_count) r.status = ST_RANGE;
          else entries[pos] = val;
        end
        CMD_FIND: begin
          r.status = ST_MISSING;
          for (int unsigned i = 0; i < fill_count; i++) begin
            if (entries[i] == val) begin
              r.status = ST_OK;
              r.index = i[7:0];
              break;
            end
          end
        end
        default: ;
      endcase
      r.fill = fill_count[8:0];
      r.empty = (fill_count == 0);
      expected_results.push_back(r);
    endfunction

    function void check_result(table_result_t got);
      table_result_t e;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) $display("unexpected result at %0t", $realtime);
        return;
      end
      e = expected_results.pop_front();
      if (got.status !== e.status || got.index !== e.index || got.removed !== e.removed ||
          got.read_value !== e.read_value || got.fill !== e.fill || got.empty !== e.empty) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("mismatch at %0t: exp st=%0d idx=%0d rm=%0d rd=%h fill=%0d empty=%0b",
                   $realtime, e.status, e.index, e.removed, e.read_value, e.fill, e.empty);
          $display("                 got st=%0d idx=%0d rm=%0d rd=%h fill=%0d empty=%0b",
                   got.status, got.index, got.removed, got.read_value, got.fill, got.empty);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [2:0]  command_i;
  logic [7:0]  position_i;
  logic [31:0] item_value_i;
  logic        done_o;
  logic [1:0]  status_o;
  logic [7:0]  result_index_o;
  logic [8:0]  removed_count_o;
  logic [31:0] read_value_o;
  logic [8:0]  fill_count_o;
  logic        is_empty_o;

  table_tracker tracker;
  int unsigned  cycles;
  int unsigned  idle_pct;

  bounded_sequence_table_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .command_i       (command_i),
    .position_i      (position_i),
    .item_value_i    (item_value_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .result_index_o  (result_index_o),
    .removed_count_o (removed_count_o),
    .read_value_o    (read_value_o),
    .fill_count_o    (fill_count_o),
    .is_empty_o      (is_empty_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    table_result_t got;
    if (rst_ni && done_o) begin
      got.status = status_e'(status_o);
      got.index = result_index_o;
      got.removed = removed_count_o;
      got.read_value = read_value_o;
      got.fill = fill_count_o;
      got.empty = is_empty_o;
      tracker.check_result(got);
    end
  end

  task automatic send_request(logic [2:0] cmd, logic [7:0] pos, logic [31:0] val);
    command_i <= cmd;
    position_i <= pos;
    item_value_i <= val;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    tracker.note_request(cmd, pos, val);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3: return $urandom;
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  task automatic random_request(bit growing);
    int unsigned n;
    int unsigned roll;
    logic [2:0]  cmd;
    logic [7:0]  pos;
    n = tracker.fill_count;
    roll = $urandom_range(99);
    if (growing) begin
      if (roll < 50) cmd = CMD_INSERT_AT;
      else if (roll < 62) cmd = CMD_INSERT_SORTED;
      else if (roll < 66) cmd = CMD_ERASE_AT;
      else if (roll < 68) cmd = CMD_REMOVE_VALUE;
      else if (roll < 78) cmd = CMD_GET;
      else if (roll < 87) cmd = CMD_SET;
      else if (roll < 97) cmd = CMD_FIND;
      else cmd = CMD_UNUSED;
    end else begin
      if (roll < 8) cmd = CMD_INSERT_AT;
      else if (roll < 14) cmd = CMD_INSERT_SORTED;
      else if (roll < 50) cmd = CMD_ERASE_AT;
      else if (roll < 60) cmd = CMD_REMOVE_VALUE;
      else if (roll < 72) cmd = CMD_GET;
      else if (roll < 82) cmd = CMD_SET;
      else if (roll < 97) cmd = CMD_FIND;
      else cmd = CMD_UNUSED;
    end
    if ($urandom_range(9) == 0) pos = 8'($urandom_range(255));
    else if (cmd == CMD_INSERT_AT) pos = 8'($urandom_range(n > 255 ? 255 : n));
    else pos = (n == 0) ? 8'd0 : 8'($urandom_range(n - 1));
    send_request(cmd, pos, pick_value());
  endtask

  initial begin
    bit growing;
    tracker = new();
    cycles = 0;
    idle_pct = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    command_i = '0;
    position_i = '0;
    item_value_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty and small table corners
    send_request(CMD_GET, 8'd0, '0);
    send_request(CMD_ERASE_AT, 8'd0, '0);
    send_request(CMD_SET, 8'd0, 32'h1234_5678);
    send_request(CMD_FIND, 8'd0, '0);
    send_request(CMD_REMOVE_VALUE, 8'd0, '0);
    send_request(CMD_INSERT_AT, 8'd1, 32'h5);
    send_request(CMD_UNUSED, 8'd255, '1);
    send_request(CMD_INSERT_SORTED, 8'd0, 32'h5);
    send_request(CMD_INSERT_AT, 8'd0, '0);
    send_request(CMD_INSERT_AT, 8'd2, '1);
    send_request(CMD_INSERT_SORTED, 8'd0, 32'h5);
    send_request(CMD_INSERT_SORTED, 8'd0, 32'h8000_0000);
    send_request(CMD_FIND, 8'd0, 32'h5);
    send_request(CMD_GET, 8'd4, '0);
    send_request(CMD_GET, 8'd255, '0);
    send_request(CMD_SET, 8'd3, 32'h5);
    send_request(CMD_REMOVE_VALUE, 8'd0, 32'h5);
    send_request(CMD_FIND, 8'd0, 32'h5);
    send_request(CMD_INSERT_AT, 8'd255, 32'h7);
    send_request(CMD_ERASE_AT, 8'd0, '0);
    send_request(CMD_GET, 8'd0, '0);
    send_request(CMD_UNUSED, 8'd0, '0);

    // grow toward full, then drain, across idle settings
    growing = 1'b1;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: idle_pct = 0;
        1: idle_pct = 47;
        2: idle_pct = 17;
        default: idle_pct = 0;
      endcase
      for (int k = 0; k < 425; k++) begin
        if (tracker.fill_count >= TABLE_DEPTH && growing) begin
          // hit the full table before draining
          send_request(CMD_INSERT_AT, 8'($urandom_range(255)), pick_value());
          send_request(CMD_INSERT_SORTED, 8'd0, pick_value());
          growing = 1'b0;
        end else if (tracker.fill_count < 8) begin
          growing = 1'b1;
        end
        random_request(growing);
      end
    end

    start <= 1'b0;
    while (tracker.expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== bounded_sequence_table_core.f =====
rtl/core/bst_pkg.sv
rtl/core/bst_cell.sv
rtl/core/bounded_sequence_table_core.sv
tb/sv/tb_bounded_sequence_table_core.sv
